// ===== src/mph_pkg.sv =====
// Shared constants, codes and types of the masked pixel histogram.
`timescale 1ns / 1ps
`default_nettype none

package mph_pkg;

    localparam int BIN_COUNT     = 256;
    localparam int SAMPLE_BITS   = 8;
    localparam int COUNT_BITS    = 24;
    localparam int SUM_BITS      = 32;
    localparam int INDEX_BITS    = 8;
    localparam int ALPHA_BITS    = 8;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;

    localparam int BIN_ADDR_BITS = $clog2(BIN_COUNT);
    localparam int DIV_BITS      = (SUM_BITS > COUNT_BITS + SAMPLE_BITS) ?
                                   SUM_BITS : COUNT_BITS + SAMPLE_BITS;
    localparam int DIV_STEP_BITS = $clog2(SAMPLE_BITS + 1);

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0]  LOW_INIT   = COUNT_BITS'(255);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [SUM_BITS-1:0]    SUM_MAX    = '1;

    typedef enum logic {
        OP_ACCUMULATE = 1'b0,
        OP_READ_BIN   = 1'b1
    } t_op;

    typedef enum logic {
        KIND_STATS = 1'b0,
        KIND_BIN   = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ALPHA_ENABLED     = 1'b0,
        CFG_TRANSPARENT_LEVEL = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_MEAN_START,
        ST_MEAN_WAIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/mph_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/mph_mean_div.sv =====
// Iterative divider for the frame mean: one quotient bit per cycle, clamped result.
`timescale 1ns / 1ps
`default_nettype none

module mph_mean_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [mph_pkg::SUM_BITS-1:0]    i_sum,
    input  wire logic [mph_pkg::COUNT_BITS-1:0]  i_total,
    output logic                                 o_done,
    output logic      [mph_pkg::SAMPLE_BITS-1:0] o_mean
);

    import mph_pkg::*;

    logic                     r_active;
    logic                     r_done;
    logic [DIV_STEP_BITS-1:0] r_steps;
    logic [DIV_BITS-1:0]      r_rem;
    logic [DIV_BITS-1:0]      r_dsh;
    logic [SAMPLE_BITS-1:0]   r_quot;

    logic [DIV_BITS-1:0] n_dividend;
    logic [DIV_BITS-1:0] n_limit;
    logic                n_fits;

    assign n_dividend = DIV_BITS'(i_sum);
    // The quotient fits the sample width only while the sum stays below total times 2^bits.
    assign n_limit    = DIV_BITS'(i_total) << SAMPLE_BITS;
    assign n_fits     = (n_dividend < n_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_steps  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_total == '0) begin
                    r_quot <= '0;
                    r_done <= 1'b1;
                end else if (!n_fits) begin
                    r_quot <= SAMPLE_MAX;
                    r_done <= 1'b1;
                end else begin
                    r_active <= 1'b1;
                    r_steps  <= DIV_STEP_BITS'(SAMPLE_BITS);
                    r_rem    <= n_dividend;
                    r_dsh    <= DIV_BITS'(i_total) << (SAMPLE_BITS - 1);
                    r_quot   <= '0;
                end
            end else if (r_active) begin
                if (r_rem >= r_dsh) begin
                    r_rem  <= r_rem - r_dsh;
                    r_quot <= {r_quot[SAMPLE_BITS-2:0], 1'b1};
                end else begin
                    r_quot <= {r_quot[SAMPLE_BITS-2:0], 1'b0};
                end
                r_dsh   <= r_dsh >> 1;
                r_steps <= r_steps - DIV_STEP_BITS'(1);
                if (r_steps == DIV_STEP_BITS'(1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_mean = r_quot;

endmodule

`default_nettype wire

// ===== src/masked_pixel_histogram.sv =====
// Top level of the masked pixel histogram with frame statistics.
//
//  Channel   Direction  Handshake                     Payload
//  command   in         start high while busy low     operation, sample, alpha, marks, bin
//  result    out        o_strobe, one cycle           kind, bin count, frame statistics
//  config    in         i_cfg_we, taken at once       i_cfg_idx, i_cfg_wdata
//
// A pixel or a bin read is accepted in ST_IDLE, then uses the bin RAM read port in
// ST_ACCESS for the read-modify-write. A last-marked pixel then starts the mean divider in
// ST_MEAN_START and waits in ST_MEAN_WAIT for the division (one quotient bit per step; no
// division when nothing was counted or the mean clamps) until the result is registered.
// A bin read result is registered from its ST_ACCESS read. Reset clears the valid bits of
// all bins at once, so no clearing pass is needed. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module masked_pixel_histogram (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_operation,
    input  wire logic [mph_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  wire logic [mph_pkg::ALPHA_BITS-1:0]      i_alpha_sample,
    input  wire logic                                i_selected,
    input  wire logic                                i_first_pixel,
    input  wire logic                                i_last_pixel,
    input  wire logic [mph_pkg::INDEX_BITS-1:0]      i_bin_index,
    input  wire logic                                i_cfg_we,
    input  wire logic [mph_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [mph_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    output logic                                     o_strobe,
    output logic                                     o_result_kind,
    output logic      [mph_pkg::COUNT_BITS-1:0]      o_bin_count,
    output logic      [mph_pkg::SAMPLE_BITS-1:0]     o_max_value,
    output logic      [mph_pkg::SAMPLE_BITS-1:0]     o_min_value,
    output logic      [mph_pkg::COUNT_BITS-1:0]      o_high_count,
    output logic      [mph_pkg::COUNT_BITS-1:0]      o_low_count,
    output logic      [mph_pkg::SAMPLE_BITS-1:0]     o_mean_value,
    output logic      [mph_pkg::COUNT_BITS-1:0]      o_counted_pixels
);

    import mph_pkg::*;

    t_state r_state;
    t_state n_state;

    // Configuration.
    logic                  r_alpha_en;
    logic [ALPHA_BITS-1:0] r_transp_level;

    // Item held during the memory access.
    t_op                      r_op;
    logic [BIN_ADDR_BITS-1:0] r_addr;
    logic [SAMPLE_BITS-1:0]   r_sample;
    logic                     r_counted;
    logic                     r_last;
    logic                     r_bin_ok;

    // Frame state.
    logic [BIN_COUNT-1:0]   r_fresh;
    logic [SAMPLE_BITS-1:0] r_max_sample;
    logic [SAMPLE_BITS-1:0] r_min_sample;
    logic [COUNT_BITS-1:0]  r_high;
    logic [COUNT_BITS-1:0]  r_low;
    logic [SUM_BITS-1:0]    r_sum;
    logic [COUNT_BITS-1:0]  r_total;

    // Result registers.
    logic                   r_strobe;
    t_kind                  r_kind;
    logic [COUNT_BITS-1:0]  r_bin_count;
    logic [SAMPLE_BITS-1:0] r_max_out;
    logic [SAMPLE_BITS-1:0] r_min_out;
    logic [COUNT_BITS-1:0]  r_high_out;
    logic [COUNT_BITS-1:0]  r_low_out;
    logic [SAMPLE_BITS-1:0] r_mean_out;
    logic [COUNT_BITS-1:0]  r_total_out;

    logic                     n_accept;
    logic                     n_counted;
    logic [BIN_ADDR_BITS-1:0] n_addr;
    logic [COUNT_BITS-1:0]    mem_rdata;
    logic [COUNT_BITS-1:0]    n_old_count;
    logic [COUNT_BITS-1:0]    n_new_count;
    logic                     n_mem_we;
    logic [SUM_BITS:0]        n_sum_wide;
    logic [SUM_BITS-1:0]      n_sum;
    logic                     div_start;
    logic                     div_done;
    logic [SAMPLE_BITS-1:0]   div_mean;

    assign busy     = (r_state != ST_IDLE);
    assign n_accept = start && !busy;

    assign n_counted = i_selected && !(r_alpha_en && (i_alpha_sample == r_transp_level));

    // Samples beyond the last bin are counted in the last bin.
    always_comb begin
        if (t_op'(i_operation) == OP_READ_BIN) begin
            n_addr = BIN_ADDR_BITS'(i_bin_index);
        end else if (32'(i_sample) >= 32'(BIN_COUNT)) begin
            n_addr = BIN_ADDR_BITS'(BIN_COUNT - 1);
        end else begin
            n_addr = BIN_ADDR_BITS'(i_sample);
        end
    end

    mph_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (n_mem_we),
        .i_waddr (r_addr),
        .i_wdata (n_new_count),
        .i_raddr (n_addr),
        .o_rdata (mem_rdata)
    );

    // A bin not yet written in this frame reads as zero.
    assign n_old_count = r_fresh[r_addr] ? mem_rdata : '0;
    assign n_new_count = (n_old_count == COUNT_MAX) ? n_old_count
                                                     : n_old_count + COUNT_BITS'(1);
    assign n_mem_we    = (r_state == ST_ACCESS) && (r_op == OP_ACCUMULATE) && r_counted;

    assign n_sum_wide = {1'b0, r_sum} + (SUM_BITS + 1)'(r_sample);
    assign n_sum      = n_sum_wide[SUM_BITS] ? SUM_MAX : n_sum_wide[SUM_BITS-1:0];

    assign div_start = (r_state == ST_MEAN_START);

    mph_mean_div u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_sum),
        .i_total (r_total),
        .o_done  (div_done),
        .o_mean  (div_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (n_accept) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (r_op == OP_ACCUMULATE && r_last) begin
                    n_state = ST_MEAN_START;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MEAN_START: begin
                n_state = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_en     <= 1'b1;
            r_transp_level <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHA_ENABLED:     r_alpha_en     <= i_cfg_wdata[0];
                CFG_TRANSPARENT_LEVEL: r_transp_level <= i_cfg_wdata[ALPHA_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_op      <= t_op'(i_operation);
            r_addr    <= n_addr;
            r_sample  <= i_sample;
            r_counted <= n_counted;
            r_last    <= i_last_pixel;
            r_bin_ok  <= (32'(i_bin_index) < 32'(BIN_COUNT));
        end
    end

    // A first-marked pixel clears the frame on its transfer, before its own update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh      <= '0;
            r_max_sample <= '0;
            r_min_sample <= SAMPLE_MAX;
            r_high       <= '0;
            r_low        <= LOW_INIT;
            r_sum        <= '0;
            r_total      <= '0;
        end else if (n_accept && t_op'(i_operation) == OP_ACCUMULATE && i_first_pixel) begin
            r_fresh      <= '0;
            r_max_sample <= '0;
            r_min_sample <= SAMPLE_MAX;
            r_high       <= '0;
            r_low        <= LOW_INIT;
            r_sum        <= '0;
            r_total      <= '0;
        end else if (n_mem_we) begin
            r_fresh[r_addr] <= 1'b1;
            if (r_sample > r_max_sample) begin
                r_max_sample <= r_sample;
            end
            if (r_sample < r_min_sample) begin
                r_min_sample <= r_sample;
            end
            if (n_new_count > r_high) begin
                r_high <= n_new_count;
            end
            if (n_new_count < r_low) begin
                r_low <= n_new_count;
            end
            r_sum <= n_sum;
            if (r_total != COUNT_MAX) begin
                r_total <= r_total + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (r_state == ST_ACCESS && r_op == OP_READ_BIN) begin
                r_strobe    <= 1'b1;
                r_kind      <= KIND_BIN;
                r_bin_count <= r_bin_ok ? n_old_count : '0;
                r_max_out   <= '0;
                r_min_out   <= '0;
                r_high_out  <= '0;
                r_low_out   <= '0;
                r_mean_out  <= '0;
                r_total_out <= '0;
            end else if (r_state == ST_MEAN_WAIT && div_done) begin
                r_strobe    <= 1'b1;
                r_kind      <= KIND_STATS;
                r_bin_count <= '0;
                r_max_out   <= r_max_sample;
                r_min_out   <= r_min_sample;
                r_high_out  <= r_high;
                r_low_out   <= r_low;
                r_mean_out  <= div_mean;
                r_total_out <= r_total;
            end
        end
    end

    assign o_strobe         = r_strobe;
    assign o_result_kind    = r_kind;
    assign o_bin_count      = r_bin_count;
    assign o_max_value      = r_max_out;
    assign o_min_value      = r_min_out;
    assign o_high_count     = r_high_out;
    assign o_low_count      = r_low_out;
    assign o_mean_value     = r_mean_out;
    assign o_counted_pixels = r_total_out;

    a_busy_after_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy
    ) else $error("block not busy after a command transfer");

    a_read_result_timing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_READ_BIN)
            |-> ##2 (o_strobe && o_result_kind == KIND_BIN)
    ) else $error("bin read result missing two cycles after its transfer");

    a_stats_order: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == KIND_STATS && o_counted_pixels != '0)
            |-> (o_max_value >= o_min_value && o_high_count >= o_low_count)
    ) else $error("frame statistics out of order");

    a_bin_result_clean: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == KIND_BIN)
            |-> (o_counted_pixels == '0 && o_mean_value == '0 && o_high_count == '0)
    ) else $error("bin read result carries statistics");

endmodule

`default_nettype wire
